// ===== sv/physical_page_allocator_assert.svh =====
// Assertion macros used by the page allocator datapath.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH

// Checks the consequent in the same cycle as the antecedent.
`define PPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define PPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ppa_pkg.sv =====
// Types and constants of the physical page allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ppa_pkg;

	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;
	localparam int CNT_W     = 13;
	localparam int ADDR_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CMP_W     = 15;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT  = 2'd1;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOT_USED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_BOOT,
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_ADD,
		S_PREP,
		S_FREE_RD,
		S_FREE_CHK,
		S_INIT_SET,
		S_SWEEP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    take;
		logic    scan_run;
		logic    alloc_commit;
		logic    mul_load;
		logic    addr_load;
		logic    idx_load;
		logic    free_rd;
		logic    free_commit;
		logic    init_load;
		logic    sweep_step;
		logic    set_status;
		status_t status_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_hit;
		logic scan_miss;
		logic below_base;
		logic idx_oor;
		logic page_taken;
		logic sweep_last;
		logic out_room;
	} sts_t;

endpackage

// ===== sv/physical_page_allocator.sv =====
// Page allocator: allocate scans at most ceil(min(page_count, MAX_PAGES)/64) map words.
// Free ends early when the address is out of range; an ignored op goes straight to the result.
// Reinitialize rewrites all ceil(MAX_PAGES/64) map words, one map word per cycle.
// One item is worked on at a time; the next is taken while a result waits in the output register.
// After reset a clearing pass over all map words runs before the first item is taken.
`timescale 1ns / 1ps

module physical_page_allocator #(
	parameter int MAX_PAGES  = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // page_address
	input  logic [1:0]                    s_axis_tuser,  // op
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [63:0]                   m_axis_tdata,  // result_address, used_pages, free_pages
	output logic [1:0]                    m_axis_tuser   // status
);

	ppa_pkg::cmd_t cmd;
	ppa_pkg::sts_t sts;
	ppa_pkg::op_t  in_op;

	assign cfg_ready = 1'b1;
	assign in_op     = ppa_pkg::op_t'(s_axis_tuser);

	ppa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_op   (in_op),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ppa_dp #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_address   (s_axis_tdata),
		.in_op        (in_op),
		.cmd          (cmd),
		.sts          (sts),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ===== sv/ppa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the allocator datapath for the page used map.
`timescale 1ns / 1ps

module ppa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/ppa_ctrl.sv =====
// Controller state machine of the page allocator.
// Depends on ppa_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module ppa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  ppa_pkg::op_t  in_op,
	output logic          in_ready,
	input  ppa_pkg::sts_t sts,
	output ppa_pkg::cmd_t cmd
);

	ppa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppa_pkg::S_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.status_code = ppa_pkg::ST_OK;
		in_ready        = 1'b0;
		unique case (state_q)
			ppa_pkg::S_BOOT: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = ppa_pkg::S_IDLE;
				end
			end
			ppa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					unique case (in_op)
						ppa_pkg::OP_ALLOC: state_d = ppa_pkg::S_SCAN;
						ppa_pkg::OP_FREE:  state_d = ppa_pkg::S_PREP;
						ppa_pkg::OP_INIT:  state_d = ppa_pkg::S_PREP;
						ppa_pkg::OP_NONE:  state_d = ppa_pkg::S_DONE;
						default:           state_d = ppa_pkg::S_DONE;
					endcase
				end
			end
			ppa_pkg::S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_hit) begin
					cmd.alloc_commit = 1'b1;
					state_d          = ppa_pkg::S_MUL;
				end else if (sts.scan_miss) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ppa_pkg::ST_NO_FREE;
					state_d         = ppa_pkg::S_DONE;
				end
			end
			ppa_pkg::S_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = ppa_pkg::S_ADD;
			end
			ppa_pkg::S_ADD: begin
				cmd.addr_load = 1'b1;
				state_d       = ppa_pkg::S_DONE;
			end
			ppa_pkg::S_PREP: begin
				if (sts.op == ppa_pkg::OP_FREE && sts.below_base) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ppa_pkg::ST_RANGE;
					state_d         = ppa_pkg::S_DONE;
				end else begin
					cmd.idx_load = 1'b1;
					state_d      = (sts.op == ppa_pkg::OP_INIT) ? ppa_pkg::S_INIT_SET
						: ppa_pkg::S_FREE_RD;
				end
			end
			ppa_pkg::S_FREE_RD: begin
				if (sts.idx_oor) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ppa_pkg::ST_RANGE;
					state_d         = ppa_pkg::S_DONE;
				end else begin
					cmd.free_rd = 1'b1;
					state_d     = ppa_pkg::S_FREE_CHK;
				end
			end
			ppa_pkg::S_FREE_CHK: begin
				if (sts.page_taken) begin
					cmd.free_commit = 1'b1;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ppa_pkg::ST_NOT_USED;
				end
				state_d = ppa_pkg::S_DONE;
			end
			ppa_pkg::S_INIT_SET: begin
				cmd.init_load = 1'b1;
				state_d       = ppa_pkg::S_SWEEP;
			end
			ppa_pkg::S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = ppa_pkg::S_DONE;
				end
			end
			ppa_pkg::S_DONE: begin
				if (sts.out_room) begin
					cmd.out_load = 1'b1;
					state_d      = ppa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ppa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/ppa_dp.sv =====
// Datapath of the page allocator: configuration, used map RAM, scan, page index shift
// (PAGE_BYTES is a power of two), counters and output register.
// Depends on ppa_pkg, ppa_ram and the assert header.
`timescale 1ns / 1ps
`include "physical_page_allocator_assert.svh"

module ppa_dp #(
	parameter int MAX_PAGES  = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [ppa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppa_pkg::ADDR_W-1:0]      cfg_data,
	input  logic [ppa_pkg::ADDR_W-1:0]      in_address,
	input  ppa_pkg::op_t                    in_op,
	input  ppa_pkg::cmd_t                   cmd,
	output ppa_pkg::sts_t                   sts,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [63:0]                     m_axis_tdata,
	output logic [1:0]                      m_axis_tuser
);

	localparam int WB     = ppa_pkg::WORD_BITS;
	localparam int WORDS  = (MAX_PAGES + WB - 1) / WB;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IDXW   = AW + ppa_pkg::BIT_W;
	localparam int CW     = ppa_pkg::CMP_W;
	localparam int NW     = ppa_pkg::CNT_W;
	localparam int PB_SH  = $clog2(PAGE_BYTES);
	localparam int RST_N  = (MAX_PAGES < 4096) ? MAX_PAGES : 4096;
	localparam int RST_RES = (RST_N + PAGE_BYTES - 1) / PAGE_BYTES;
	localparam logic [NW-1:0] RST_USED = NW'(RST_RES);
	localparam logic [NW-1:0] RST_FREE = NW'(RST_N - RST_RES);

	logic [ppa_pkg::ADDR_W-1:0] base_q;
	logic [NW-1:0]              page_count_q;
	logic [NW-1:0]              n;
	logic [CW-1:0]              nwords;

	logic [NW-1:0]              used_q, free_q;
	logic [ppa_pkg::BIT_W-1:0]  reserved_q;
	logic [AW:0]                cnt_q;
	logic                       rdv_s1;
	logic [AW-1:0]              rword_s1;

	ppa_pkg::op_t               op_q;
	logic [ppa_pkg::ADDR_W-1:0] addr_q;
	logic [IDXW-1:0]            idx_q;
	logic [ppa_pkg::ADDR_W-1:0] prod_q;
	logic [ppa_pkg::ADDR_W-1:0] res_q;
	ppa_pkg::status_t           status_q;

	logic [ppa_pkg::ADDR_W-1:0] dq_q;

	logic                       out_valid_q;

	logic                       ram_we, ram_re, issue;
	logic [AW-1:0]              ram_waddr, ram_raddr, free_word;
	logic [WB-1:0]              ram_wdata, rdata;
	logic [WB-1:0]              mask, free_bits, sweep_word;
	logic [CW-1:0]              lim;
	logic [ppa_pkg::BIT_W-1:0]  bitpos, free_bit;

	assign n = (32'(page_count_q) > 32'(MAX_PAGES)) ? NW'(MAX_PAGES) : page_count_q;
	assign nwords = (CW'(n) + CW'(WB - 1)) >> ppa_pkg::BIT_W;

	assign free_word = dq_q[IDXW-1:ppa_pkg::BIT_W];
	assign free_bit  = dq_q[ppa_pkg::BIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= 32'h0010_0000;
			page_count_q <= 13'd4096;
		end else if (cfg_valid) begin
			if (cfg_index == ppa_pkg::REG_REGION_BASE) begin
				base_q <= cfg_data;
			end else if (cfg_index == ppa_pkg::REG_PAGE_COUNT) begin
				page_count_q <= cfg_data[NW-1:0];
			end
		end
	end

	// Scan: one map word is read per cycle and checked in the following cycle.
	assign issue = cmd.scan_run && (CW'(cnt_q) < nwords);
	assign lim   = CW'(n) - (CW'(rword_s1) << ppa_pkg::BIT_W);
	assign mask  = (lim >= CW'(WB)) ? '1 : ((WB'(1) << lim[ppa_pkg::BIT_W-1:0]) - WB'(1));
	assign free_bits = ~rdata & mask;

	always_comb begin
		bitpos = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				bitpos = ppa_pkg::BIT_W'(i);
			end
		end
	end

	assign sweep_word = (cnt_q == '0) ?
		((WB'(1) << reserved_q) - WB'(1)) : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = sweep_word;
		if (cmd.sweep_step) begin
			ram_we = 1'b1;
		end else if (cmd.alloc_commit) begin
			ram_we    = 1'b1;
			ram_waddr = rword_s1;
			ram_wdata = rdata | (WB'(1) << bitpos);
		end else if (cmd.free_commit) begin
			ram_we    = 1'b1;
			ram_waddr = free_word;
			ram_wdata = rdata & ~(WB'(1) << free_bit);
		end
		ram_re    = issue || cmd.free_rd;
		ram_raddr = cmd.free_rd ? free_word : cnt_q[AW-1:0];
	end

	ppa_ram #(
		.WIDTH(WB),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= RST_USED;
			free_q      <= RST_FREE;
			reserved_q  <= ppa_pkg::BIT_W'(RST_RES);
			cnt_q       <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= issue;
			if (cmd.take || cmd.init_load) begin
				cnt_q <= '0;
			end else if (issue || cmd.sweep_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.init_load) begin
				reserved_q <= dq_q[ppa_pkg::BIT_W-1:0];
				used_q     <= NW'(dq_q[ppa_pkg::BIT_W-1:0]);
				free_q     <= n - NW'(dq_q[ppa_pkg::BIT_W-1:0]);
			end else if (cmd.alloc_commit) begin
				used_q <= (used_q == ppa_pkg::COUNT_MAX) ? used_q : used_q + 1'b1;
				free_q <= (free_q == '0) ? free_q : free_q - 1'b1;
			end else if (cmd.free_commit) begin
				used_q <= (used_q == '0) ? used_q : used_q - 1'b1;
				free_q <= (free_q == ppa_pkg::COUNT_MAX) ? free_q : free_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rword_s1 <= cnt_q[AW-1:0];
		if (cmd.take) begin
			op_q     <= in_op;
			addr_q   <= in_address;
			res_q    <= '0;
			status_q <= ppa_pkg::ST_OK;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.addr_load) begin
				res_q <= base_q + prod_q;
			end
		end
		if (cmd.alloc_commit) begin
			idx_q <= {rword_s1, bitpos};
		end
		if (cmd.mul_load) begin
			prod_q <= 32'(idx_q) * 32'(PAGE_BYTES);
		end
		if (cmd.idx_load) begin
			dq_q <= (op_q == ppa_pkg::OP_INIT)
				? ((32'(n) + 32'(PAGE_BYTES - 1)) >> PB_SH)
				: ((addr_q - base_q) >> PB_SH);
		end
		if (cmd.out_load) begin
			m_axis_tdata <= {6'd0, free_q, used_q, res_q};
			m_axis_tuser <= status_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;

	assign sts.op         = op_q;
	assign sts.scan_hit   = rdv_s1 && (|free_bits);
	assign sts.scan_miss  = (nwords == '0)
		|| (rdv_s1 && !(|free_bits) && (CW'(rword_s1) == nwords - 1'b1));
	assign sts.below_base = addr_q < base_q;
	assign sts.idx_oor    = dq_q >= 32'(n);
	assign sts.page_taken = rdata[free_bit];
	assign sts.sweep_last = CW'(cnt_q) == CW'(WORDS - 1);
	assign sts.out_room   = !out_valid_q || m_axis_tready;

	`PPA_ASSERT_NOW(a_alloc_bit_free, cmd.alloc_commit, rdv_s1 && !rdata[bitpos], "alloc marks a used page")
	`PPA_ASSERT_NOW(a_free_bit_used, cmd.free_commit, rdata[free_bit], "free clears a free page")
	`PPA_ASSERT_NOW(a_out_no_overwrite, cmd.out_load, !out_valid_q || m_axis_tready, "result overwritten")
	`PPA_ASSERT_NOW(a_one_writer, 1'b1, $onehot0({cmd.sweep_step, cmd.alloc_commit, cmd.free_commit}), "map write conflict")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for physical_page_allocator: first-fit page allocation, free and
// reinitialize over several base and page count settings, with random stalls on both streams.
// Depends on ppa_pkg and the physical_page_allocator top level.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_PAGES  = 4096;
	localparam int PAGE_BYTES = 4096;
	localparam int CNT_W      = ppa_pkg::CNT_W;
	localparam int CFG_IDX_W  = ppa_pkg::CFG_IDX_W;

	typedef struct {
		logic [31:0]      address;
		ppa_pkg::status_t status;
		logic [CNT_W-1:0] used_pages;
		logic [CNT_W-1:0] free_pages;
	} reply_t;

	class alloc_tracker;
		bit               taken_map[MAX_PAGES];
		logic [31:0]      region_base;
		logic [CNT_W-1:0] page_count;
		logic [CNT_W-1:0] used_count;
		logic [CNT_W-1:0] free_count;
		reply_t           pending_replies[$];
		int               errors;

		function new();
			region_base = 32'h0010_0000;
			page_count  = 13'd4096;
			errors      = 0;
			reinit();
		endfunction

		function int active_pages();
			return (page_count > MAX_PAGES) ? MAX_PAGES : int'(page_count);
		endfunction

		function void reinit();
			int n;
			int reserved;
			n = active_pages();
			reserved = (n + PAGE_BYTES - 1) / PAGE_BYTES;
			foreach (taken_map[i]) taken_map[i] = (i < reserved) && (i < n);
			used_count = CNT_W'(reserved);
			free_count = CNT_W'(n - reserved);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
			if (index == ppa_pkg::REG_REGION_BASE) begin
				region_base = value;
			end else if (index == ppa_pkg::REG_PAGE_COUNT) begin
				page_count = value[CNT_W-1:0];
			end
		endfunction

		function void take_request(ppa_pkg::op_t op, logic [31:0] addr);
			reply_t      r;
			int          n;
			int          slot;
			logic [31:0] idx;
			n = active_pages();
			r.address = '0;
			r.status = ppa_pkg::ST_OK;
			case (op)
				ppa_pkg::OP_ALLOC: begin
					slot = -1;
					for (int i = 0; i < n; i++) begin
						if (!taken_map[i]) begin
							slot = i;
							break;
						end
					end
					if (slot < 0) begin
						r.status = ppa_pkg::ST_NO_FREE;
					end else begin
						taken_map[slot] = 1'b1;
						if (used_count != ppa_pkg::COUNT_MAX) used_count++;
						if (free_count != 0) free_count--;
						r.address = region_base + 32'(slot * PAGE_BYTES);
					end
				end
				ppa_pkg::OP_FREE: begin
					if (addr < region_base) begin
						r.status = ppa_pkg::ST_RANGE;
					end else begin
						idx = (addr - region_base) / 32'(PAGE_BYTES);
						if (idx >= 32'(n)) begin
							r.status = ppa_pkg::ST_RANGE;
						end else if (!taken_map[idx]) begin
							r.status = ppa_pkg::ST_NOT_USED;
						end else begin
							taken_map[idx] = 1'b0;
							if (used_count != 0) used_count--;
							if (free_count != ppa_pkg::COUNT_MAX) free_count++;
						end
					end
				end
				ppa_pkg::OP_INIT: begin
					reinit();
				end
				default: begin
				end
			endcase
			r.used_pages = used_count;
			r.free_pages = free_count;
			pending_replies.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void match_reply(logic [63:0] data, logic [1:0] st);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual tdata %h tuser %h",
					$time, data, st);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			compare("result_address", want.address, data[31:0]);
			compare("status", 32'(want.status), 32'(st));
			compare("used_pages", 32'(want.used_pages), 32'(data[44:32]));
			compare("free_pages", 32'(want.free_pages), 32'(data[57:45]));
			compare("padding", 32'd0, 32'(data[63:58]));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;  // page_address
	logic [1:0]           s_axis_tuser;  // op
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [63:0]          m_axis_tdata;  // result_address, used_pages, free_pages
	logic [1:0]           m_axis_tuser;  // status

	alloc_tracker tracker;
	bit           quiet;
	int           stall_left;
	int           hold;

	logic [31:0]      phase_base[9];
	logic [CNT_W-1:0] phase_pages[9];
	bit               phase_init[9];

	physical_page_allocator #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		return quiet ? 0 : int'($urandom_range(0, 16));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_axis_tready) begin
			if (m_axis_tvalid) begin
				tracker.match_reply(m_axis_tdata, m_axis_tuser);
				hold = pick_gap();
				if (hold > 0) begin
					m_axis_tready <= 1'b0;
					stall_left <= hold;
				end
			end
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_replies.size() != 0);
	endtask

	task automatic send_request(input ppa_pkg::op_t op, input logic [31:0] addr);
		int gap;
		gap = pick_gap();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= addr;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_request(op, addr);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(index, value);
	endtask

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int          roll;
		int          lim;
		logic [31:0] base;
		logic [31:0] addr;
		tracker = new();
		quiet = 1'b0;
		phase_base = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_8000, 32'h1234_5000,
			32'h7ABC_D123, 32'h0010_0000, 32'h0010_0000, 32'h8000_0000, 32'h0000_0000};
		phase_pages = '{13'd8, 13'd16, 13'd4096, 13'd0, 13'd8191, 13'd33, 13'd5, 13'd4096, 13'd1};
		phase_init = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= ppa_pkg::OP_NONE;
		cfg_valid <= 1'b0;
		cfg_index <= ppa_pkg::REG_REGION_BASE;
		cfg_data <= '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		base = tracker.region_base;
		send_request(ppa_pkg::OP_ALLOC, 32'h0000_0000);
		send_request(ppa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
		send_request(ppa_pkg::OP_FREE, base + PAGE_BYTES);
		send_request(ppa_pkg::OP_FREE, base + PAGE_BYTES);
		send_request(ppa_pkg::OP_FREE, 32'h0000_0000);
		send_request(ppa_pkg::OP_FREE, base + MAX_PAGES * PAGE_BYTES);
		send_request(ppa_pkg::OP_FREE, 32'hFFFF_FFFF);
		send_request(ppa_pkg::OP_ALLOC, 32'h5555_AAAA);
		send_request(ppa_pkg::OP_FREE, base + PAGE_BYTES + 123);
		send_request(ppa_pkg::OP_FREE, base);
		send_request(ppa_pkg::OP_ALLOC, 32'h0000_0000);
		send_request(ppa_pkg::OP_NONE, 32'hFFFF_FFFF);
		send_request(ppa_pkg::OP_INIT, 32'hAAAA_5555);
		send_request(ppa_pkg::OP_ALLOC, 32'h0000_0000);
		write_register(ppa_pkg::REG_PAGE_COUNT, 32'd2);
		send_request(ppa_pkg::OP_INIT, 32'h0000_0000);
		send_request(ppa_pkg::OP_ALLOC, 32'h0000_0000);
		send_request(ppa_pkg::OP_ALLOC, 32'h0000_0000);
		send_request(ppa_pkg::OP_FREE, base + 2 * PAGE_BYTES - 1);
		write_register(ppa_pkg::REG_PAGE_COUNT, 32'd0);
		send_request(ppa_pkg::OP_INIT, 32'h0000_0000);
		send_request(ppa_pkg::OP_ALLOC, 32'h0000_0000);
		send_request(ppa_pkg::OP_FREE, base);
		write_register(ppa_pkg::REG_PAGE_COUNT, 32'd8);
		send_request(ppa_pkg::OP_ALLOC, 32'h0000_0000);
		send_request(ppa_pkg::OP_FREE, base);

		for (int p = 0; p < 9; p++) begin
			write_register(ppa_pkg::REG_REGION_BASE, phase_base[p]);
			write_register(ppa_pkg::REG_PAGE_COUNT, 32'(phase_pages[p]));
			quiet = ($urandom_range(0, 3) == 0);
			if (phase_init[p]) send_request(ppa_pkg::OP_INIT, $urandom());
			for (int k = 0; k < 75; k++) begin
				if ($urandom_range(0, 59) == 0) wait_drained();
				roll = $urandom_range(0, 99);
				lim = (tracker.active_pages() < 48) ? tracker.active_pages() : 48;
				if (roll < 45) begin
					send_request(ppa_pkg::OP_ALLOC, $urandom());
				end else if (roll < 80) begin
					addr = tracker.region_base + 32'($urandom_range(0, lim)) * 32'(PAGE_BYTES);
					if ($urandom_range(0, 2) == 0) addr = addr + $urandom_range(0, PAGE_BYTES - 1);
					send_request(ppa_pkg::OP_FREE, addr);
				end else if (roll < 88) begin
					send_request(ppa_pkg::OP_FREE, $urandom());
				end else if (roll < 93) begin
					send_request(ppa_pkg::OP_FREE, tracker.region_base - $urandom_range(1, 8192));
				end else if (roll < 97) begin
					send_request(ppa_pkg::OP_INIT, $urandom());
				end else begin
					send_request(ppa_pkg::OP_NONE, $urandom());
				end
			end
		end

		wait_drained();
		repeat (150) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
